/* hw/rtl/ite_pkg.sv */
// ----------------------------------------------------------------------------
// ite_pkg
// Shared types, word codes and sizing constants for the integer to English
// words block.
// ----------------------------------------------------------------------------
package ite_pkg;

  // Sizing
  localparam int VALUE_BITS_DEF  = 31;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int BITS_PER_STEP   = 4;   // binary bits folded into BCD per cycle
  localparam int NUM_GROUPS      = 4;   // units, thousands, millions, billions
  localparam int NUM_DIGITS      = NUM_GROUPS * 3;
  localparam int SLOTS_PER_GROUP = 5;
  localparam int NUM_SLOTS       = NUM_GROUPS * SLOTS_PER_GROUP;
  localparam int MAX_WORDS       = 16;
  localparam int WORD_W          = 5;

  // Word slots within one group, in the order they are spoken
  localparam int SLOT_HDIGIT  = 0;
  localparam int SLOT_HUNDRED = 1;
  localparam int SLOT_TENS    = 2;
  localparam int SLOT_ONES    = 3;
  localparam int SLOT_SCALE   = 4;

  typedef logic [WORD_W-1:0] word_t;

  // Word codes
  localparam word_t W_ZERO      = 5'd0;
  localparam word_t W_TEN       = 5'd10;
  localparam word_t W_TENS_BASE = 5'd18;
  localparam word_t W_HUNDRED   = 5'd28;
  localparam word_t W_THOUSAND  = 5'd29;

  typedef logic [NUM_DIGITS-1:0][3:0] digits_t;

  // One classified number travelling from the front to the back
  typedef struct packed {
    digits_t                digits;
    logic [NUM_SLOTS-1:0]   present;  // slot index 0 is the most significant group
  } ite_entry_t;

endpackage

/* hw/rtl/integer_to_english_words.sv */
// Names an unsigned integer in English as a run of 5-bit word codes, most
// significant three-digit group first, one word per transfer on the output,
// with last_word set on the final word of each number. The front converts the
// value to BCD four bits per cycle and can take the next number in the cycle
// that the finished one enters the queue. The back emits one word per cycle
// while the output is not stalled, and starts on the next queued number
// straight after the last word of the previous one. A zero value gives the
// single word Zero, and a run is cut at sixteen words.
// ----------------------------------------------------------------------------
// integer_to_english_words
// Top level: BCD front, short queue and word sequencer back.
// ----------------------------------------------------------------------------
module integer_to_english_words #(
  parameter int VALUE_BITS  = ite_pkg::VALUE_BITS_DEF,
  parameter int QUEUE_DEPTH = ite_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // Input channel: one number per transfer
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [VALUE_BITS-1:0] value,
  // Output channel: one word per transfer
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [4:0]            word_code,
  output logic                  last_word
);
  import ite_pkg::*;

  // Front to queue and queue to back
  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_empty;
  ite_entry_t push_entry;
  ite_entry_t pop_entry;

  // The front holds a converted number until the queue has room.
  ite_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .value      (value),
    .push       (q_push),
    .push_entry (push_entry),
    .q_full     (q_full)
  );

  // The queue lets the front convert the next number while the back is still
  // speaking the previous one, or is held by a stalled output.
  ite_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .pop_entry  (pop_entry),
    .full       (q_full),
    .empty      (q_empty)
  );

  // The back keeps a registered output stage; a held word stops the back, and
  // the front is blocked only once the queue is full.
  ite_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_entry   (pop_entry),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .word_code (word_code),
    .last_word (last_word)
  );

`ifndef SYNTHESIS
  // The front must never write into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("queue written while full");

  // The back must never take from an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("queue read while empty");

  // A number is converted in the F_CONV state, so the input is held after a
  // transfer.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a conversion runs");

  // Zero is only ever spoken on its own.
  a_zero_alone: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (word_code == W_ZERO)) |-> last_word)
    else $error("Zero word not marked as last");
`endif

endmodule

/* hw/rtl/ite_front.sv */
// ----------------------------------------------------------------------------
// ite_front
// Accepts a value, converts it to BCD a few bits per cycle and marks which
// word slots of each three-digit group will be spoken.
// ----------------------------------------------------------------------------
module ite_front #(
  parameter int VALUE_BITS = ite_pkg::VALUE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [VALUE_BITS-1:0]  value,
  output logic                   push,
  output ite_pkg::ite_entry_t    push_entry,
  input  logic                   q_full
);
  import ite_pkg::*;

  localparam int STEPS  = (VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int SHW    = STEPS * BITS_PER_STEP;
  localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int BCD_W  = NUM_DIGITS * 4;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_CONV = 3'b010,
    F_HOLD = 3'b100
  } front_state_t;

  front_state_t       state, state_next;
  logic [SHW-1:0]     shreg, shreg_next;
  logic [BCD_W-1:0]   bcd, bcd_next;
  logic [STEP_W-1:0]  step;
  logic               accept;
  logic [NUM_SLOTS-1:0] present;
  digits_t            dg;

  assign in_stall = !((state == F_IDLE) || ((state == F_HOLD) && !q_full));
  assign accept   = in_valid && !in_stall;
  assign push     = (state == F_HOLD) && !q_full;

  // Double dabble: several add-3 and shift steps per cycle
  always_comb begin
    bcd_next   = bcd;
    shreg_next = shreg;
    for (int k = 0; k < BITS_PER_STEP; k++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (bcd_next[d*4 +: 4] >= 4'd5) begin
          bcd_next[d*4 +: 4] = bcd_next[d*4 +: 4] + 4'd3;
        end
      end
      bcd_next   = {bcd_next[BCD_W-2:0], shreg_next[SHW-1]};
      shreg_next = {shreg_next[SHW-2:0], 1'b0};
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: begin
        if (accept) state_next = F_CONV;
      end
      F_CONV: begin
        if (step == STEP_W'(STEPS - 1)) state_next = F_HOLD;
      end
      F_HOLD: begin
        if (accept) state_next = F_CONV;
        else if (push) state_next = F_IDLE;
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      shreg <= SHW'(value);
      bcd   <= '0;
      step  <= '0;
    end else if (state == F_CONV) begin
      shreg <= shreg_next;
      bcd   <= bcd_next;
      step  <= step + STEP_W'(1);
    end
  end

  // Classify: which of the five word slots of each group are spoken
  assign dg = digits_t'(bcd);

  always_comb begin
    present = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      // g = 0 is the most significant group
      present[g*SLOTS_PER_GROUP + SLOT_HDIGIT]  = dg[3*(NUM_GROUPS-1-g)+2] != 4'd0;
      present[g*SLOTS_PER_GROUP + SLOT_HUNDRED] = dg[3*(NUM_GROUPS-1-g)+2] != 4'd0;
      present[g*SLOTS_PER_GROUP + SLOT_TENS]    = dg[3*(NUM_GROUPS-1-g)+1] >= 4'd2;
      present[g*SLOTS_PER_GROUP + SLOT_ONES]    = (dg[3*(NUM_GROUPS-1-g)+1] == 4'd1) ||
                                                  (dg[3*(NUM_GROUPS-1-g)] != 4'd0);
      present[g*SLOTS_PER_GROUP + SLOT_SCALE]   = (g != NUM_GROUPS-1) &&
          ((dg[3*(NUM_GROUPS-1-g)+2] | dg[3*(NUM_GROUPS-1-g)+1] |
            dg[3*(NUM_GROUPS-1-g)]) != 4'd0);
    end
  end

  assign push_entry.digits  = dg;
  assign push_entry.present = present;

endmodule

/* hw/rtl/ite_fifo.sv */
// ----------------------------------------------------------------------------
// ite_fifo
// Short register queue between the front and the back.
// ----------------------------------------------------------------------------
module ite_fifo #(
  parameter int DEPTH = ite_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  ite_pkg::ite_entry_t push_entry,
  input  logic                pop,
  output ite_pkg::ite_entry_t pop_entry,
  output logic                full,
  output logic                empty
);
  import ite_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ite_entry_t      mem [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;

  assign full      = count == CW'(DEPTH);
  assign empty     = count == '0;
  assign pop_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

endmodule

/* hw/rtl/ite_back.sv */
// ----------------------------------------------------------------------------
// ite_back
// Walks the marked word slots of one number and emits one word per cycle,
// while the output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module ite_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  ite_pkg::ite_entry_t q_entry,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [4:0]          word_code,
  output logic                last_word
);
  import ite_pkg::*;

  localparam int IDX_W = $clog2(NUM_SLOTS);
  localparam int CNT_W = $clog2(MAX_WORDS);

  ite_entry_t          ent;
  logic                active;
  logic [IDX_W-1:0]    cursor;
  logic [CNT_W-1:0]    wcnt;
  logic                found;
  logic                more;
  logic [IDX_W-1:0]    sel;
  word_t               code;
  logic                is_last;
  logic                advance;
  logic                load;

  function automatic word_t slot_word(digits_t dg, int gi, int s);
    logic [3:0] h;
    logic [3:0] t;
    logic [3:0] o;
    word_t      w;
    h = dg[3*gi+2];
    t = dg[3*gi+1];
    o = dg[3*gi];
    unique case (s)
      SLOT_HDIGIT:  w = {1'b0, h};
      SLOT_HUNDRED: w = W_HUNDRED;
      SLOT_TENS:    w = W_TENS_BASE + {1'b0, t};
      SLOT_ONES:    w = (t == 4'd1) ? W_TEN + {1'b0, o} : {1'b0, o};
      default:      w = W_THOUSAND + WORD_W'(gi - 1);
    endcase
    return w;
  endfunction

  // First spoken slot at or after the cursor, and whether any follows it
  always_comb begin
    found = 1'b0;
    sel   = '0;
    code  = W_ZERO;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      for (int s = 0; s < SLOTS_PER_GROUP; s++) begin
        if (!found && ent.present[g*SLOTS_PER_GROUP + s] &&
            (IDX_W'(g*SLOTS_PER_GROUP + s) >= cursor)) begin
          found = 1'b1;
          sel   = IDX_W'(g*SLOTS_PER_GROUP + s);
          code  = slot_word(ent.digits, NUM_GROUPS - 1 - g, s);
        end
      end
    end
    more = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (ent.present[i] && (IDX_W'(i) > sel)) more = 1'b1;
    end
  end

  // Zero alone has no marked slot and gives the single word Zero
  assign is_last = !found || !more || (wcnt == CNT_W'(MAX_WORDS - 1));
  assign advance = active && (!out_valid || !out_stall);
  assign load    = !active || (advance && is_last);
  assign pop     = load && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        active <= 1'b1;
      end else if (advance && is_last) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      word_code <= code;
      last_word <= is_last;
    end
    if (pop) begin
      ent    <= q_entry;
      cursor <= '0;
      wcnt   <= '0;
    end else if (advance) begin
      cursor <= sel + IDX_W'(1);
      wcnt   <= wcnt + CNT_W'(1);
    end
  end

endmodule
